FILE: rtl/dnsar_pkg.sv
`default_nettype none

package dnsar_pkg;

   // message limits
   localparam int MAX_MESSAGE_BYTES = 512;
   localparam int BYTE_INDEX_WIDTH  = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int POS_WIDTH         = 12;
   localparam int WP_WIDTH          = POS_WIDTH + 1;
   localparam int POS_LIMIT         = 4096;
   localparam int WCOUNT_WIDTH      = 5;
   localparam int QUEUE_DEPTH       = 4;

   // header byte offsets
   localparam logic [BYTE_INDEX_WIDTH-1:0] HDR_FLAGS_HI_IDX = BYTE_INDEX_WIDTH'(2);
   localparam logic [BYTE_INDEX_WIDTH-1:0] HDR_FLAGS_LO_IDX = BYTE_INDEX_WIDTH'(3);
   localparam logic [BYTE_INDEX_WIDTH-1:0] HDR_QD_HI_IDX    = BYTE_INDEX_WIDTH'(4);
   localparam logic [BYTE_INDEX_WIDTH-1:0] HDR_QD_LO_IDX    = BYTE_INDEX_WIDTH'(5);
   localparam logic [BYTE_INDEX_WIDTH-1:0] HDR_COUNTS_IDX   = BYTE_INDEX_WIDTH'(6);
   localparam logic [BYTE_INDEX_WIDTH-1:0] HDR_LAST_IDX     = BYTE_INDEX_WIDTH'(11);

   // protocol constants
   localparam logic [7:0]  FLAGS_HI        = 8'h81;
   localparam logic [7:0]  FLAGS_LO        = 8'h80;
   localparam logic [15:0] OPCODE_MASK     = 16'h7800;
   localparam logic [7:0]  POINTER_MIN     = 8'd192;
   localparam logic [7:0]  POINTER_TAG     = 8'hc0;
   localparam logic [7:0]  TTL_LOW         = 8'h3c;
   localparam logic [7:0]  RDLENGTH_LOW    = 8'h04;
   localparam logic [7:0]  ONE_LOW         = 8'h01;
   localparam logic [7:0]  TYPECLASS_BYTES = 8'd4;
   localparam logic [31:0] TYPE_CLASS_A_IN = 32'h0001_0001;
   localparam logic [POS_WIDTH-1:0] PATCH_HI_POS = POS_WIDTH'(6);
   localparam logic [POS_WIDTH-1:0] PATCH_LO_POS = POS_WIDTH'(7);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_QSTART,
      PH_NAME,
      PH_LABEL,
      PH_PTR2,
      PH_TYPECLASS,
      PH_DONE
   } phase_type;

   // one classified transaction handed from the parser to the writer
   typedef struct packed {
      logic [7:0]              data;
      logic [POS_WIDTH-1:0]    base;
      logic [WCOUNT_WIDTH-1:0] write_count;
      logic [POS_WIDTH-1:0]    qstart_pos;
      logic                    last;
      logic [15:0]             answers;
      logic                    drop;
      logic [POS_WIDTH-1:0]    length;
   } cmd_type;

   // byte k of the 16-byte A answer
   function automatic logic [7:0] answer_byte(input logic [3:0] k,
                                              input logic [POS_WIDTH-1:0] qs,
                                              input logic [31:0] addr);
      logic [7:0] r;
      unique case (k)
         4'd0:    r = POINTER_TAG | {4'h0, qs[11:8]};
         4'd1:    r = qs[7:0];
         4'd3:    r = ONE_LOW;
         4'd5:    r = ONE_LOW;
         4'd9:    r = TTL_LOW;
         4'd11:   r = RDLENGTH_LOW;
         4'd12:   r = addr[31:24];
         4'd13:   r = addr[23:16];
         4'd14:   r = addr[15:8];
         4'd15:   r = addr[7:0];
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/dns_a_record_responder_top.sv
// path: a query byte's first write passes the transaction queue, then the output register
// throughput: one query byte a cycle in, one write a cycle out of the writer's single port
// a type A class IN question adds 16 answer writes and the last byte adds two count patches,
// so input stalls while the 4-entry transaction queue is full; rsp_stall holds writes
// reset: synchronous, active high; clears parse state, queue, output valid and the address
`default_nettype none

module dns_a_record_responder_top (
   input  wire                              clock,
   input  wire                              reset,
   // query bytes
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [7:0]                       req_query_byte,
   input  wire                              req_last_byte,
   // response writes
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [7:0]                       rsp_out_byte,
   output logic [dnsar_pkg::POS_WIDTH-1:0]  rsp_out_position,
   output logic                             rsp_is_final,
   output logic                             rsp_verdict,
   output logic [dnsar_pkg::POS_WIDTH-1:0]  rsp_reply_length,
   // answer address register
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [31:0]                      csr_answer_address
);
   import dnsar_pkg::*;

   logic [31:0] answer_address_ff, answer_address_in;

   cmd_type     push_cmd;
   cmd_type     head;
   logic        push;
   logic        pop;
   logic        queue_full;
   logic        queue_empty;

   // the register takes a write in any cycle
   assign csr_ready         = 1'b1;
   assign answer_address_in = (csr_valid && csr_ready) ? csr_answer_address : answer_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         answer_address_ff <= '0;
      end else begin
         answer_address_ff <= answer_address_in;
      end
   end

   // input is held off only while the queue has no free slot
   assign req_stall = queue_full;

   // parser: walks header and questions, tracks response position,
   // answer count and drop verdict, at most one transaction per accepted byte
   dnsar_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_query_byte (req_query_byte),
      .req_last_byte  (req_last_byte),
      .queue_full     (queue_full),
      .push           (push),
      .cmd            (push_cmd)
   );

   // decouples parsing from the answer bursts
   dnsar_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head     (head)
   );

   // writer: expands each transaction into copied byte, answer bytes
   // and count patches through one output register
   dnsar_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .queue_empty      (queue_empty),
      .answer_address   (answer_address_ff),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_position (rsp_out_position),
      .rsp_is_final     (rsp_is_final),
      .rsp_verdict      (rsp_verdict),
      .rsp_reply_length (rsp_reply_length)
   );

endmodule

`default_nettype wire

FILE: rtl/dnsar_queue.sv
`default_nettype none

module dnsar_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  dnsar_pkg::cmd_type  push_cmd,
   input  wire                 pop,
   output logic                full,
   output logic                empty,
   output dnsar_pkg::cmd_type  head
);
   import dnsar_pkg::*;

   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   cmd_type                entries_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   assign full  = (count_ff == COUNT_WIDTH'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dnsar_front.sv
`default_nettype none

module dnsar_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire  [7:0]          req_query_byte,
   input  wire                 req_last_byte,
   input  wire                 queue_full,
   output logic                push,
   output dnsar_pkg::cmd_type  cmd
);
   import dnsar_pkg::*;

   logic [BYTE_INDEX_WIDTH-1:0] byte_index_ff, byte_index_in;
   logic [WP_WIDTH-1:0]         write_position_ff, write_position_in;
   logic [15:0]                 header_hold_ff, header_hold_in;
   logic [15:0]                 questions_left_ff, questions_left_in;
   phase_type                   phase_ff, phase_in, phase_after;
   logic [7:0]                  label_left_ff, label_left_in;
   logic [31:0]                 type_class_ff, type_class_in;
   logic [POS_WIDTH-1:0]        qstart_pos_ff, qstart_pos_in;
   logic [15:0]                 answers_made_ff, answers_made_in;
   logic                        drop_ff, drop_in;

   logic                        accept;
   logic                        take;
   logic [BYTE_INDEX_WIDTH-1:0] idx;
   logic [7:0]                  b;
   logic [7:0]                  label_dec;
   logic [31:0]                 type_class_shift;
   logic [15:0]                 questions_dec;
   logic                        emit;
   logic                        answer;
   logic [7:0]                  out_data;
   logic [15:0]                 answers_after;
   logic                        drop_after;
   logic [WCOUNT_WIDTH-1:0]     count;
   logic [WP_WIDTH-1:0]         room;
   logic [WCOUNT_WIDTH-1:0]     write_count;
   logic [WP_WIDTH-1:0]         wp_after;

   assign accept           = req_valid && !queue_full;
   assign take             = byte_index_ff < BYTE_INDEX_WIDTH'(MAX_MESSAGE_BYTES);
   assign idx              = byte_index_ff;
   assign b                = req_query_byte;
   assign label_dec        = label_left_ff - 8'd1;
   assign type_class_shift = {type_class_ff[23:0], b};
   assign questions_dec    = questions_left_ff - 16'd1;

   // parse phase after this byte
   always_comb begin
      phase_after = phase_ff;
      if (accept && take) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (idx == HDR_LAST_IDX) begin
                  phase_after = (questions_left_ff == '0) ? PH_DONE : PH_QSTART;
               end
            end
            PH_QSTART, PH_NAME: begin
               priority if (b == 8'd0) begin
                  phase_after = PH_TYPECLASS;
               end else if (b >= POINTER_MIN) begin
                  phase_after = PH_PTR2;
               end else begin
                  phase_after = PH_LABEL;
               end
            end
            PH_LABEL: begin
               if (label_dec == '0) begin
                  phase_after = PH_NAME;
               end
            end
            PH_PTR2: begin
               phase_after = PH_TYPECLASS;
            end
            PH_TYPECLASS: begin
               if (label_dec == '0) begin
                  phase_after = (questions_dec == '0) ? PH_DONE : PH_QSTART;
               end
            end
            PH_DONE: begin
               phase_after = PH_DONE;
            end
            default: begin
               phase_after = phase_ff;
            end
         endcase
      end
   end

   assign phase_in = (accept && req_last_byte) ? PH_HEADER : phase_after;

   // datapath and transaction fields
   always_comb begin
      byte_index_in     = byte_index_ff;
      header_hold_in    = header_hold_ff;
      questions_left_in = questions_left_ff;
      label_left_in     = label_left_ff;
      type_class_in     = type_class_ff;
      answers_after     = answers_made_ff;
      drop_after        = drop_ff;
      emit              = 1'b0;
      answer            = 1'b0;
      out_data          = b;

      if (accept && take) begin
         byte_index_in = byte_index_ff + 1'b1;
         unique case (phase_ff)
            PH_HEADER: begin
               emit = 1'b1;
               priority if (idx == HDR_FLAGS_HI_IDX) begin
                  header_hold_in = {b, 8'h00};
                  out_data       = FLAGS_HI;
               end else if (idx == HDR_FLAGS_LO_IDX) begin
                  if (((header_hold_ff | {8'h00, b}) & OPCODE_MASK) != '0) begin
                     drop_after = 1'b1;
                  end
                  out_data = FLAGS_LO;
               end else if (idx >= HDR_COUNTS_IDX) begin
                  out_data = 8'h00;
               end else begin
                  if (idx == HDR_QD_HI_IDX) begin
                     header_hold_in = {8'h00, b};
                  end
                  if (idx == HDR_QD_LO_IDX) begin
                     questions_left_in = {header_hold_ff[7:0], b};
                     if ({header_hold_ff[7:0], b} == 16'd0) begin
                        drop_after = 1'b1;
                     end
                  end
               end
            end
            PH_QSTART, PH_NAME: begin
               emit = 1'b1;
               priority if (b == 8'd0) begin
                  label_left_in = TYPECLASS_BYTES;
                  type_class_in = '0;
               end else if (b >= POINTER_MIN) begin
                  label_left_in = label_left_ff;
               end else begin
                  label_left_in = b;
               end
            end
            PH_LABEL: begin
               emit          = 1'b1;
               label_left_in = label_dec;
            end
            PH_PTR2: begin
               emit          = 1'b1;
               label_left_in = TYPECLASS_BYTES;
               type_class_in = '0;
            end
            PH_TYPECLASS: begin
               emit          = 1'b1;
               type_class_in = type_class_shift;
               label_left_in = label_dec;
               if (label_dec == '0) begin
                  answer            = (type_class_shift == TYPE_CLASS_A_IN);
                  answers_after     = answers_made_ff + 16'(answer);
                  questions_left_in = questions_dec;
               end
            end
            PH_DONE: begin
               emit = 1'b0;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end

      // writes past the end of the response are suppressed and force a drop
      count = WCOUNT_WIDTH'(emit) + (answer ? WCOUNT_WIDTH'(16) : '0);
      room  = WP_WIDTH'(POS_LIMIT) - write_position_ff;
      if (WP_WIDTH'(count) > room) begin
         write_count = room[WCOUNT_WIDTH-1:0];
         drop_after  = 1'b1;
      end else begin
         write_count = count;
      end
      wp_after = write_position_ff + WP_WIDTH'(write_count);

      qstart_pos_in     = (take && phase_after == PH_QSTART && accept)
                          ? wp_after[POS_WIDTH-1:0] : qstart_pos_ff;
      write_position_in = wp_after;
      answers_made_in   = answers_after;
      drop_in           = drop_after;

      cmd.data        = out_data;
      cmd.base        = write_position_ff[POS_WIDTH-1:0];
      cmd.write_count = write_count;
      cmd.qstart_pos  = qstart_pos_ff;
      cmd.last        = req_last_byte;
      cmd.answers     = answers_after;
      cmd.drop        = drop_after || !(phase_after == PH_QSTART || phase_after == PH_DONE);
      cmd.length      = (wp_after == WP_WIDTH'(POS_LIMIT)) ? '1 : wp_after[POS_WIDTH-1:0];

      // end of message: back to the reset state
      if (accept && req_last_byte) begin
         byte_index_in     = '0;
         write_position_in = '0;
         header_hold_in    = '0;
         questions_left_in = '0;
         label_left_in     = '0;
         type_class_in     = '0;
         qstart_pos_in     = '0;
         answers_made_in   = '0;
         drop_in           = 1'b0;
      end
   end

   assign push = accept && (write_count != '0 || req_last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff     <= '0;
         write_position_ff <= '0;
         header_hold_ff    <= '0;
         questions_left_ff <= '0;
         phase_ff          <= PH_HEADER;
         label_left_ff     <= '0;
         type_class_ff     <= '0;
         qstart_pos_ff     <= '0;
         answers_made_ff   <= '0;
         drop_ff           <= 1'b0;
      end else begin
         byte_index_ff     <= byte_index_in;
         write_position_ff <= write_position_in;
         header_hold_ff    <= header_hold_in;
         questions_left_ff <= questions_left_in;
         phase_ff          <= phase_in;
         label_left_ff     <= label_left_in;
         type_class_ff     <= type_class_in;
         qstart_pos_ff     <= qstart_pos_in;
         answers_made_ff   <= answers_made_in;
         drop_ff           <= drop_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dnsar_back.sv
`default_nettype none

module dnsar_back (
   input  wire                              clock,
   input  wire                              reset,
   input  dnsar_pkg::cmd_type               head,
   input  wire                              queue_empty,
   input  wire  [31:0]                      answer_address,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [7:0]                       rsp_out_byte,
   output logic [dnsar_pkg::POS_WIDTH-1:0]  rsp_out_position,
   output logic                             rsp_is_final,
   output logic                             rsp_verdict,
   output logic [dnsar_pkg::POS_WIDTH-1:0]  rsp_reply_length
);
   import dnsar_pkg::*;

   logic [WCOUNT_WIDTH-1:0] step_ff, step_in;
   logic                    valid_ff, valid_in;
   logic [7:0]              byte_ff, byte_in;
   logic [POS_WIDTH-1:0]    position_ff, position_in;
   logic                    final_ff, final_in;
   logic                    verdict_ff, verdict_in;
   logic [POS_WIDTH-1:0]    length_ff, length_in;

   logic                    advance;
   logic [WCOUNT_WIDTH-1:0] end_step;
   logic [WCOUNT_WIDTH-1:0] answer_step;

   // a last transaction carries two extra steps for the count patches
   assign advance     = !queue_empty && (!valid_ff || !rsp_stall);
   assign end_step    = head.write_count + (head.last ? WCOUNT_WIDTH'(2) : WCOUNT_WIDTH'(0))
                        - WCOUNT_WIDTH'(1);
   assign answer_step = step_ff - WCOUNT_WIDTH'(1);
   assign pop         = advance && (step_ff == end_step);

   always_comb begin
      step_in     = step_ff;
      valid_in    = valid_ff && rsp_stall;
      byte_in     = byte_ff;
      position_in = position_ff;
      final_in    = final_ff;
      verdict_in  = verdict_ff;
      length_in   = length_ff;
      if (advance) begin
         valid_in = 1'b1;
         step_in  = (step_ff == end_step) ? '0 : step_ff + 1'b1;
         priority if (step_ff < head.write_count) begin
            byte_in     = (step_ff == '0) ? head.data
                          : answer_byte(answer_step[3:0], head.qstart_pos, answer_address);
            position_in = head.base + POS_WIDTH'(step_ff);
            final_in    = 1'b0;
            verdict_in  = 1'b0;
            length_in   = '0;
         end else if (step_ff == head.write_count) begin
            byte_in     = head.answers[15:8];
            position_in = PATCH_HI_POS;
            final_in    = 1'b0;
            verdict_in  = 1'b0;
            length_in   = '0;
         end else begin
            byte_in     = head.answers[7:0];
            position_in = PATCH_LO_POS;
            final_in    = 1'b1;
            verdict_in  = head.drop;
            length_in   = head.length;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      position_ff <= position_in;
      final_ff    <= final_in;
      verdict_ff  <= verdict_in;
      length_ff   <= length_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_out_position = position_ff;
   assign rsp_is_final     = final_ff;
   assign rsp_verdict      = verdict_ff;
   assign rsp_reply_length = length_ff;

endmodule

`default_nettype wire
